// ----- rtl/sapd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared types and constants for the prefix-doubling suffix array block.
// ----------------------------------------------------------------------------
package sapd_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int SYM_W       = 8;
    localparam int QRANK_W     = 10;
    localparam int START_W     = 10;

    typedef struct packed {
        logic               kind;
        logic [SYM_W-1:0]   symbol;
        logic               last;
        logic [QRANK_W-1:0] query_rank;
    } in_t;

    typedef struct packed {
        logic [START_W-1:0] suffix_start;
        logic               in_range;
        logic               overflowed;
    } out_t;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SHIFT,
        ST_ROTLOAD,
        ST_ROTATE,
        ST_UPDATE,
        ST_DUMP
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INIT,
        CELL_SHIFT,
        CELL_ROTLOAD,
        CELL_ROTATE,
        CELL_UPDATE,
        CELL_DUMP
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [SYM_W-1:0] symbol;
    } cell_ctl_t;

endpackage

// ----- rtl/sapd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sapd_ram #(
    parameter int W = 10,
    parameter int D = 1024
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sapd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapd_cell
// One text position: rank, second key, a passing rank pair and a less-than count.
// ----------------------------------------------------------------------------
module sapd_cell #(
    parameter int RW = 10,
    parameter int LW = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sapd_pkg::cell_ctl_t ctl,
    input  logic                sel,
    input  logic                valid,
    input  logic [RW:0]         nxt_s,
    input  logic [RW-1:0]       nxt_r,
    input  logic [RW-1:0]       nxt_rot_r,
    input  logic [RW:0]         nxt_rot_s,
    input  logic                nxt_rot_v,
    output logic [RW-1:0]       r,
    output logic [RW:0]         s,
    output logic [RW-1:0]       rot_r,
    output logic [RW:0]         rot_s,
    output logic                rot_v
);

    logic [RW-1:0] r_reg;
    logic [RW:0]   s_reg;
    logic [RW-1:0] rot_r_reg;
    logic [RW:0]   rot_s_reg;
    logic          rot_v_reg;
    logic [LW-1:0] cnt_reg;
    logic          less;

    // passing pair sorts strictly before this cell's pair
    assign less = rot_v_reg && ((rot_r_reg < r_reg) ||
                                ((rot_r_reg == r_reg) && (rot_s_reg < s_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_v_reg <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                sapd_pkg::CELL_ROTLOAD: rot_v_reg <= valid;
                sapd_pkg::CELL_ROTATE:  rot_v_reg <= nxt_rot_v;
                default:                rot_v_reg <= rot_v_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            sapd_pkg::CELL_LOAD:
            begin
                if (sel)
                begin
                    r_reg <= RW'(ctl.symbol);
                end
            end
            sapd_pkg::CELL_INIT:
            begin
                s_reg   <= valid ? ((RW + 1)'(r_reg) + 1'b1) : '0;
                cnt_reg <= '0;
            end
            sapd_pkg::CELL_SHIFT:
            begin
                s_reg <= nxt_s;
            end
            sapd_pkg::CELL_ROTLOAD:
            begin
                rot_r_reg <= r_reg;
                rot_s_reg <= s_reg;
            end
            sapd_pkg::CELL_ROTATE:
            begin
                if (less)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                rot_r_reg <= nxt_rot_r;
                rot_s_reg <= nxt_rot_s;
            end
            sapd_pkg::CELL_UPDATE:
            begin
                r_reg <= RW'(cnt_reg);
            end
            sapd_pkg::CELL_DUMP:
            begin
                r_reg <= nxt_r;
            end
            default:
            begin
            end
        endcase
    end

    assign r     = r_reg;
    assign s     = s_reg;
    assign rot_r = rot_r_reg;
    assign rot_s = rot_s_reg;
    assign rot_v = rot_v_reg;

endmodule

// ----- rtl/suffix_array_prefix_doubling.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling
// Suffix array builder on a row of position cells, with a rank-to-start RAM.
// ----------------------------------------------------------------------------
// Appends are taken while busy is low; the last one starts the build.
// Queries go back to back, strobe the cycle after (registered RAM read).
// Build after the last symbol: P passes of init, shift by pow, rotate and
// update, with P = ceil(log2(n)) (at least 1), then n ranks unload into
// the RAM; each rotation takes rank pairs around the MAX_LEN-cell ring.
// Reset clears length, overflow and control; the receiver cannot stall.
// ----------------------------------------------------------------------------
module suffix_array_prefix_doubling #(
    parameter int MAX_LEN = sapd_pkg::MAX_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sapd_pkg::in_t  request,
    output logic           result_valid,
    output sapd_pkg::out_t result
);

    localparam int LW = $clog2(MAX_LEN);
    localparam int RW = (LW > sapd_pkg::SYM_W) ? LW : sapd_pkg::SYM_W;
    localparam int CW = LW + 1;

    sapd_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             new_reg, new_next;      // next append opens a fresh load
    logic [CW-1:0]    pow_reg, pow_next;
    logic [CW-1:0]    cyc_reg, cyc_next;
    logic             rv_reg, rv_next;
    logic             inr_reg, inr_next;
    logic             rovf_reg, rovf_next;

    sapd_pkg::cell_ctl_t ctl;
    logic [CW-1:0]       len_eff;
    logic                load_en;
    logic                ram_we;
    logic [LW-1:0]       ram_q;

    // cell row wiring
    logic [RW-1:0] c_r     [MAX_LEN];
    logic [RW:0]   c_s     [MAX_LEN];
    logic [RW-1:0] c_rot_r [MAX_LEN];
    logic [RW:0]   c_rot_s [MAX_LEN];
    logic          c_rot_v [MAX_LEN];

    // busy is low exactly in idle
    wire accept = start && (state_reg == sapd_pkg::ST_IDLE);

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sapd_pkg::ST_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            new_reg   <= 1'b1;
            pow_reg   <= '0;
            cyc_reg   <= '0;
            rv_reg    <= 1'b0;
            inr_reg   <= 1'b0;
            rovf_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            new_reg   <= new_next;
            pow_reg   <= pow_next;
            cyc_reg   <= cyc_next;
            rv_reg    <= rv_next;
            inr_reg   <= inr_next;
            rovf_reg  <= rovf_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        new_next   = new_reg;
        pow_next   = pow_reg;
        cyc_next   = cyc_reg;
        rv_next    = 1'b0;
        inr_next   = inr_reg;
        rovf_next  = rovf_reg;
        ctl.op     = sapd_pkg::CELL_HOLD;
        ctl.symbol = request.symbol;
        load_en    = 1'b0;
        ram_we     = 1'b0;
        busy       = 1'b1;
        len_eff    = new_reg ? '0 : len_reg;

        case (state_reg)
            sapd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (accept && request.kind == sapd_pkg::KIND_APPEND)
                begin
                    new_next = 1'b0;
                    if (new_reg)
                    begin
                        ovf_next = 1'b0;
                    end
                    if (len_eff < CW'(MAX_LEN))
                    begin
                        load_en  = 1'b1;
                        ctl.op   = sapd_pkg::CELL_LOAD;
                        len_next = len_eff + 1'b1;
                    end
                    else
                    begin
                        len_next = len_eff;
                        ovf_next = 1'b1;
                    end
                    if (request.last)
                    begin
                        pow_next   = CW'(1);
                        state_next = sapd_pkg::ST_INIT;
                    end
                end
                else if (accept)
                begin
                    // query: a finished build must exist
                    rv_next   = 1'b1;
                    inr_next  = new_reg && ((CW + sapd_pkg::QRANK_W)'(request.query_rank) <
                                            (CW + sapd_pkg::QRANK_W)'(len_reg));
                    rovf_next = ovf_reg;
                end
            end
            sapd_pkg::ST_INIT:
            begin
                ctl.op     = sapd_pkg::CELL_INIT;
                cyc_next   = '0;
                state_next = sapd_pkg::ST_SHIFT;
            end
            sapd_pkg::ST_SHIFT:
            begin
                // second keys slide pow cells toward position zero
                ctl.op   = sapd_pkg::CELL_SHIFT;
                cyc_next = cyc_reg + 1'b1;
                if (cyc_reg == pow_reg - 1'b1)
                begin
                    state_next = sapd_pkg::ST_ROTLOAD;
                end
            end
            sapd_pkg::ST_ROTLOAD:
            begin
                ctl.op     = sapd_pkg::CELL_ROTLOAD;
                cyc_next   = '0;
                state_next = sapd_pkg::ST_ROTATE;
            end
            sapd_pkg::ST_ROTATE:
            begin
                // every pair visits every cell once; each counts smaller pairs
                ctl.op   = sapd_pkg::CELL_ROTATE;
                cyc_next = cyc_reg + 1'b1;
                if (cyc_reg == CW'(MAX_LEN - 1))
                begin
                    state_next = sapd_pkg::ST_UPDATE;
                end
            end
            sapd_pkg::ST_UPDATE:
            begin
                ctl.op   = sapd_pkg::CELL_UPDATE;
                pow_next = pow_reg << 1;
                cyc_next = '0;
                if ((pow_reg << 1) < len_reg)
                begin
                    state_next = sapd_pkg::ST_INIT;
                end
                else
                begin
                    state_next = sapd_pkg::ST_DUMP;
                end
            end
            sapd_pkg::ST_DUMP:
            begin
                // ranks are distinct now; unload through cell zero
                ctl.op   = sapd_pkg::CELL_DUMP;
                ram_we   = 1'b1;
                cyc_next = cyc_reg + 1'b1;
                if (cyc_reg == len_reg - 1'b1)
                begin
                    new_next   = 1'b1;
                    state_next = sapd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sapd_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- cell row ----------------
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        localparam int KN = (k + 1) % MAX_LEN;
        logic [RW:0]   ns;
        logic [RW-1:0] nr;

        if (k == MAX_LEN - 1)
        begin : g_end
            assign ns = '0;
            assign nr = '0;
        end
        else
        begin : g_mid
            assign ns = c_s[KN];
            assign nr = c_r[KN];
        end

        sapd_cell #(
            .RW (RW),
            .LW (LW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sel       (load_en && (len_eff == CW'(k))),
            .valid     (CW'(k) < len_reg),
            .nxt_s     (ns),
            .nxt_r     (nr),
            .nxt_rot_r (c_rot_r[KN]),
            .nxt_rot_s (c_rot_s[KN]),
            .nxt_rot_v (c_rot_v[KN]),
            .r         (c_r[k]),
            .s         (c_s[k]),
            .rot_r     (c_rot_r[k]),
            .rot_s     (c_rot_s[k]),
            .rot_v     (c_rot_v[k])
        );
    end

    // ---------------- rank to start position ----------------
    sapd_ram #(
        .W (LW),
        .D (MAX_LEN)
    ) u_sfx (
        .clk   (clk),
        .we    (ram_we),
        .waddr (LW'(c_r[0])),
        .wdata (LW'(cyc_reg)),
        .raddr (LW'(request.query_rank)),
        .rdata (ram_q)
    );

    assign result_valid        = rv_reg;
    assign result.suffix_start = inr_reg ? sapd_pkg::START_W'(ram_q) : '0;
    assign result.in_range     = inr_reg;
    assign result.overflowed   = rovf_reg;

`ifndef ASSERT_OFF
    a_res_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.kind == sapd_pkg::KIND_QUERY) |=> result_valid)
        else $error("query transaction without result strobe");

    a_inrange_built: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.in_range) |-> new_reg)
        else $error("in-range result while no finished build");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sapd_pkg::ST_IDLE) |-> (len_reg != '0 && pow_reg != '0))
        else $error("build running on empty text or zero stride");
`endif

endmodule
